// File: src/fcm_pkg.sv
package fcm_pkg;

   // Field widths of the request and response transfers
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 16;
   localparam int VALUE_W = 16;
   localparam int STAT_W  = 2;
   localparam int BLOCK_W = 16;
   localparam int TALLY_W = 13;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 32;

   // Width used for unsigned compares between counters and the entry count
   localparam int CMP_W = 17;

   // Table entry that closes a chain, and a free entry
   localparam logic [BLOCK_W-1:0] END_MARK   = 16'hFFFF;
   localparam logic [BLOCK_W-1:0] FREE_ENTRY = 16'h0000;

   // Reset value of the block count register
   localparam logic [TALLY_W-1:0] BLOCKS_RESET = 13'd4096;

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_LOAD   = 3'd0;
   localparam mode_type MODE_NEXT   = 3'd1;
   localparam mode_type MODE_APPEND = 3'd2;
   localparam mode_type MODE_FREE   = 3'd3;
   localparam mode_type MODE_COUNT  = 3'd4;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type STAT_OK     = 2'd0;
   localparam status_type STAT_NOFREE = 2'd1;
   localparam status_type STAT_RANGE  = 2'd2;
   localparam status_type STAT_LONG   = 2'd3;

   // Request transfer layout, mode in the lowest bits
   typedef struct packed {
      logic [REQ_W-MODE_W-INDEX_W-VALUE_W-1:0] pad;
      logic [VALUE_W-1:0]                      value;
      logic [INDEX_W-1:0]                      index;
      mode_type                                mode;
   } req_type;

   // Response transfer layout, status in the lowest bits
   typedef struct packed {
      logic [RSP_W-STAT_W-BLOCK_W-TALLY_W-1:0] pad;
      logic [TALLY_W-1:0]                      tally;
      logic [BLOCK_W-1:0]                      block;
      status_type                              status;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       capture;     // latch a request and start a fresh result
      logic       clr;         // clear one entry of the reset pass
      logic       scan;        // advance the first-fit / counting scan
      logic       scan_count;  // count free entries seen by the scan
      logic       pick;        // hold the scan hit as the chosen block
      logic       read_cur;    // read the entry at the current index
      logic       load_wr;     // write the request value at the current index
      logic       take_block;  // hold the read entry as the result block
      logic       link_wr;     // write the chosen block into the tail entry
      logic       mark_wr;     // mark the chosen block as a chain end
      logic       walk_clear;  // clear the walked entry and follow its link
      logic       set_status;  // load the status code below
      status_type status;
      logic       block_end;   // load the end mark as the result block
      logic       out_load;    // move the result to the response register
   } fcm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      mode_type mode;
      logic     cur_none;
      logic     cur_in_range;
      logic     tally_full;
      logic     scan_more;
      logic     scan_pend;
      logic     hit;
      logic     clr_last;
   } fcm_stat_type;

endpackage

// File: src/fcm_ctrl.sv
module fcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  fcm_pkg::fcm_stat_type stat,
   output fcm_pkg::fcm_cmd_type  cmd
);
   import fcm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SCAN,
      ST_LINK,
      ST_MARK,
      ST_WALK_CHECK,
      ST_WALK_CLEAR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequence one operation
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.status   = STAT_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (stat.mode)
               MODE_LOAD: begin
                  if (stat.cur_in_range) begin
                     cmd.load_wr = 1'b1;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end
               end
               MODE_NEXT: begin
                  if (stat.cur_in_range) begin
                     cmd.read_cur = 1'b1;
                     state_in     = ST_READ_WAIT;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end
               end
               MODE_APPEND: begin
                  if (!stat.cur_none && !stat.cur_in_range) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               MODE_FREE: begin
                  state_in = ST_WALK_CHECK;
               end
               MODE_COUNT: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_READ_WAIT: begin
            cmd.take_block = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan       = 1'b1;
            cmd.scan_count = (stat.mode == MODE_COUNT);
            if (stat.mode == MODE_APPEND && stat.hit) begin
               cmd.pick = 1'b1;
               state_in = ST_LINK;
            end else if (!stat.scan_more && !stat.scan_pend) begin
               if (stat.mode == MODE_APPEND) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STAT_NOFREE;
                  cmd.block_end  = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         ST_LINK: begin
            cmd.link_wr = !stat.cur_none;
            state_in    = ST_MARK;
         end
         ST_MARK: begin
            cmd.mark_wr = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_WALK_CHECK: begin
            if (stat.cur_none) begin
               state_in = ST_FINISH;
            end else if (!stat.cur_in_range) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_RANGE;
               state_in       = ST_FINISH;
            end else if (stat.tally_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_LONG;
               state_in       = ST_FINISH;
            end else begin
               cmd.read_cur = 1'b1;
               state_in     = ST_WALK_CLEAR;
            end
         end
         ST_WALK_CLEAR: begin
            cmd.walk_clear = 1'b1;
            state_in       = ST_WALK_CHECK;
         end
         ST_FINISH: begin
            // Hold the result until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/fcm_datapath.sv
module fcm_datapath #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fcm_pkg::fcm_cmd_type         cmd,
   output fcm_pkg::fcm_stat_type        stat,
   input  logic [fcm_pkg::REQ_W-1:0]   req_data,
   input  logic                        csr_wr_en,
   input  logic [fcm_pkg::TALLY_W-1:0] csr_wr_data,
   output logic [fcm_pkg::RSP_W-1:0]   rsp_data
);
   import fcm_pkg::*;

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_BLOCKS);
   localparam logic [AW-1:0]    LAST_ADR = AW'(MAX_BLOCKS - 1);

   req_type req;
   rsp_type rsp_ff;

   // Allocation table and its registered read
   logic [BLOCK_W-1:0] mem_ff [MAX_BLOCKS];
   logic [BLOCK_W-1:0] rd_data_ff;

   logic [TALLY_W-1:0] blocks_ff, blocks_in;
   logic [AW:0]        scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [INDEX_W-1:0] cur_ff, cur_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [AW-1:0]      tag_ff;
   logic [AW-1:0]      pick_ff;
   mode_type           mode_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [TALLY_W-1:0] n_ff;
   logic [BLOCK_W-1:0] block_ff;
   status_type         status_ff;

   logic               scan_more;
   logic               hit;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [BLOCK_W-1:0] wr_data;

   assign req      = req_type'(req_data);
   assign rsp_data = RSP_W'(rsp_ff);

   assign scan_more = CMP_W'(scan_ff) < CMP_W'(n_ff);
   assign hit       = pend_ff && (rd_data_ff == FREE_ENTRY);

   // Report to the controller
   always_comb begin
      stat.mode         = mode_ff;
      stat.cur_none     = (cur_ff == END_MARK);
      stat.cur_in_range = CMP_W'(cur_ff) < CMP_W'(n_ff);
      stat.tally_full   = (tally_ff >= n_ff);
      stat.scan_more    = scan_more;
      stat.scan_pend    = pend_ff;
      stat.hit          = hit;
      stat.clr_last     = (scan_ff[AW-1:0] == LAST_ADR);
   end

   // Next values of the counters and walk pointer
   always_comb begin
      blocks_in = csr_wr_en ? csr_wr_data : blocks_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      cur_in    = cur_ff;
      tally_in  = tally_ff;
      if (cmd.capture) begin
         scan_in  = '0;
         pend_in  = 1'b0;
         cur_in   = req.index;
         tally_in = '0;
      end
      if (cmd.clr) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.scan) begin
         pend_in = scan_more;
         if (scan_more) begin
            scan_in = scan_ff + 1'b1;
         end
         if (cmd.scan_count && hit) begin
            tally_in = tally_ff + 1'b1;
         end
      end
      if (cmd.walk_clear) begin
         cur_in   = rd_data_ff;
         tally_in = tally_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= BLOCKS_RESET;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         blocks_ff <= blocks_in;
         scan_ff   <= scan_in;
         pend_ff   <= pend_in;
      end
   end

   // Hold request fields and result payload
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      tally_ff <= tally_in;
      if (cmd.capture) begin
         mode_ff   <= req.mode;
         val_ff    <= req.value;
         n_ff      <= (CMP_W'(blocks_ff) > MAX_EXT) ? TALLY_W'(MAX_BLOCKS) : blocks_ff;
         block_ff  <= '0;
         status_ff <= STAT_OK;
      end
      if (cmd.scan) begin
         tag_ff <= scan_ff[AW-1:0];
      end
      if (cmd.pick) begin
         pick_ff <= tag_ff;
      end
      if (cmd.take_block) begin
         block_ff <= rd_data_ff;
      end
      if (cmd.mark_wr) begin
         block_ff <= BLOCK_W'(pick_ff);
      end
      if (cmd.block_end) begin
         block_ff <= END_MARK;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.out_load) begin
         rsp_ff.pad    <= '0;
         rsp_ff.status <= status_ff;
         rsp_ff.block  <= block_ff;
         rsp_ff.tally  <= tally_ff;
      end
   end

   // Select the table read and write ports
   always_comb begin
      rd_en   = (cmd.scan && scan_more) || cmd.read_cur;
      rd_addr = cmd.scan ? scan_ff[AW-1:0] : cur_ff[AW-1:0];
      wr_en   = cmd.clr || cmd.load_wr || cmd.link_wr || cmd.mark_wr || cmd.walk_clear;
      wr_addr = cur_ff[AW-1:0];
      wr_data = FREE_ENTRY;
      if (cmd.clr) begin
         wr_addr = scan_ff[AW-1:0];
      end else if (cmd.mark_wr) begin
         wr_addr = pick_ff;
         wr_data = END_MARK;
      end else if (cmd.link_wr) begin
         wr_data = BLOCK_W'(pick_ff);
      end else if (cmd.load_wr) begin
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// File: src/fat_chain_manager_unit.sv
// Allocation table manager for 16-bit chained block lists.
// Request channel (req_*): one transfer carries mode, index and value; the
// unit takes a request only when no operation is in progress. Response
// channel (rsp_*): exactly one transfer per request, in request order, with
// status, block and tally. csr_wr_en / csr_wr_data set the number of valid
// entries; write it only while the unit is idle.
// Scanning and walking requests (n = valid entries):
//   append: first-fit scan, one table read per cycle;
//   count_free: the same scan over the n entries;
//   free_chain: read each entry, then clear it and follow its link.
// The table has one registered read and one write per cycle.
// After reset the table is swept to all free, one entry per cycle; no
// request is taken during the sweep, CSR writes are.
// The response is held in an output register: a stalled receiver does not
// block the next request, but a second result waits until the first is taken.
module fat_chain_manager_unit #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mode[2:0], index[18:3], value[34:19], zero[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[1:0], block[17:2], tally[30:18], zero[31]
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   import fcm_pkg::*;

   fcm_cmd_type  cmd;
   fcm_stat_type stat;

   // Sequence operations
   fcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Table, counters and result registers
   fcm_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule
